FILE: rtl/flt_pkg.sv
// ----------------------------------------------------------------------------
// flt_pkg
// Shared types and constants of the frequency leader tracker: item and
// result payloads, controller/datapath command and status groups, states.
// ----------------------------------------------------------------------------
package flt_pkg;

	localparam int TABLE_ENTRIES = 64;
	localparam int COUNT_BITS    = 16;

	localparam int VALUE_W = 32;
	localparam int FIELD_COUNT_W = 16;
	localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int USED_W  = $clog2(TABLE_ENTRIES + 1);
	localparam int ENTRY_W = VALUE_W + COUNT_BITS;

	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [USED_W-1:0]     used_t;

	localparam count_t COUNT_MAX = {COUNT_BITS{1'b1}};

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      last;
	} item_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0]  leader_value;
		logic [FIELD_COUNT_W-1:0]   leader_count;
		logic                       overflow;
		logic                       final_res;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_CMP,
		ST_INSERT,
		ST_DONE
	} ctl_state_t;

	typedef struct packed {
		logic load;     // capture the item, rewind the scan pointer
		logic rd;       // read entry at the scan pointer
		logic hit_wr;   // bump the matched entry
		logic advance;  // step the scan pointer
		logic insert;   // add the value as a new entry, or flag the drop
		logic finish;   // result cycle, clear the set after a last item
	} dp_cmd_t;

	typedef struct packed {
		logic used_zero;
		logic match;
		logic at_end;
	} dp_status_t;

	// Fit an internal count into the 16-bit result field.
	function automatic logic [FIELD_COUNT_W-1:0] count_to_field(input count_t c);
		logic [31:0] wide;
		wide = 32'(c);
		return wide[FIELD_COUNT_W-1:0];
	endfunction

endpackage

FILE: rtl/flt_ctrl.sv
// ----------------------------------------------------------------------------
// flt_ctrl
// Sequencer: takes an item, scans the table one entry per read, then either
// bumps the matching entry or inserts a new one (flagging a drop when the
// table is full), and presents the result.
module flt_ctrl import flt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  dp_status_t status,
	output dp_cmd_t    cmd,
	output logic       busy,
	output logic       done
);

	ctl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = status.used_zero ? ST_INSERT : ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_CMP;
			end
			ST_CMP: begin
				if (status.match) begin
					state_d = ST_DONE;
				end else if (status.at_end) begin
					state_d = ST_INSERT;
				end else begin
					state_d = ST_READ;
				end
			end
			ST_INSERT: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		done = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			ST_READ: begin
				cmd.rd = 1'b1;
			end
			ST_CMP: begin
				cmd.hit_wr  = status.match;
				cmd.advance = !status.match && !status.at_end;
			end
			ST_INSERT: begin
				cmd.insert = 1'b1;
			end
			ST_DONE: begin
				cmd.finish = 1'b1;
				done       = 1'b1;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

endmodule

FILE: rtl/flt_datapath.sv
// ----------------------------------------------------------------------------
// flt_datapath
// Entry memory (key and count), fill count, scan pointer, leader registers
// and the sticky overflow flag. Entries fill in order, so the fill count
// alone tells which entries are live.
// ----------------------------------------------------------------------------
module flt_datapath import flt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  item_t      item,
	input  dp_cmd_t    cmd,
	output dp_status_t status,
	output result_t    result
);

	logic [ENTRY_W-1:0] entry_mem_q [TABLE_ENTRIES];
	logic [ENTRY_W-1:0] rd_q;

	logic signed [VALUE_W-1:0] value_q;
	logic                      last_q;
	idx_t                      ptr_q;
	used_t                     used_q;
	logic signed [VALUE_W-1:0] best_value_q;
	count_t                    best_count_q;
	logic                      dropped_q;

	logic [VALUE_W-1:0] rd_key;
	count_t             rd_count;
	count_t             hit_count;
	logic               full;
	logic               wr_en;
	idx_t               wr_idx;
	logic [ENTRY_W-1:0] wr_data;

	assign rd_key    = rd_q[ENTRY_W-1 -: VALUE_W];
	assign rd_count  = rd_q[COUNT_BITS-1:0];
	assign hit_count = (rd_count == COUNT_MAX) ? rd_count : rd_count + count_t'(1);
	assign full      = (used_q == used_t'(TABLE_ENTRIES));

	assign status.used_zero = (used_q == '0);
	assign status.match     = (rd_key == value_q);
	assign status.at_end    = ((used_t'(ptr_q) + used_t'(1)) == used_q);

	assign wr_en   = cmd.hit_wr || (cmd.insert && !full);
	assign wr_idx  = cmd.hit_wr ? ptr_q : used_q[IDX_W-1:0];
	assign wr_data = cmd.hit_wr ? {rd_key, hit_count} : {value_q, count_t'(1)};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_mem_q[wr_idx] <= wr_data;
		end
		if (cmd.rd) begin
			rd_q <= entry_mem_q[ptr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			value_q <= item.value;
			last_q  <= item.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q        <= '0;
			used_q       <= '0;
			best_value_q <= '0;
			best_count_q <= '0;
			dropped_q    <= 1'b0;
		end else begin
			if (cmd.load) begin
				ptr_q <= '0;
			end else if (cmd.advance) begin
				ptr_q <= ptr_q + idx_t'(1);
			end

			if (cmd.hit_wr && (hit_count > best_count_q)) begin
				best_value_q <= value_q;
				best_count_q <= hit_count;
			end

			if (cmd.insert) begin
				if (full) begin
					dropped_q <= 1'b1;
				end else begin
					used_q <= used_q + used_t'(1);
					if (best_count_q == '0) begin
						best_value_q <= value_q;
						best_count_q <= count_t'(1);
					end
				end
			end

			// drop the whole set once its final result has gone out
			if (cmd.finish && last_q) begin
				used_q       <= '0;
				best_value_q <= '0;
				best_count_q <= '0;
				dropped_q    <= 1'b0;
			end
		end
	end

	assign result.leader_value = best_value_q;
	assign result.leader_count = count_to_field(best_count_q);
	assign result.overflow     = dropped_q;
	assign result.final_res    = last_q;

endmodule

FILE: rtl/frequency_leader_tracker.sv
// ----------------------------------------------------------------------------
// frequency_leader_tracker
// Streaming mode counter: counts distinct values in a bounded table and
// reports the leader (first value to reach the highest count) per item.
//
//   channel  ports                  transfer
//   -------  ---------------------  -------------------------------------
//   input    start, busy, item      start high while busy low
//   output   done, result           done high for one cycle, no backpressure
//
// The table scan reads (ST_READ) and compares (ST_CMP) one live entry at a
// time through the single read port of the entry memory, until a match or
// the last entry; an empty table skips it. A hit is bumped from ST_CMP, a
// new value goes through ST_INSERT. busy drops the cycle after done.
// Reset clears the fill count, leader and overflow flag; entry memory needs
// no clearing pass. Results cannot be stalled.
// ----------------------------------------------------------------------------
module frequency_leader_tracker import flt_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  item_t   item,
	output logic    busy,
	output logic    done,
	output result_t result
);

	dp_cmd_t    cmd;
	dp_status_t status;

	flt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	flt_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.status (status),
		.result (result)
	);

`ifndef SYNTHESIS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("accepted item did not raise busy");

	a_done_release: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("busy held after result");

	a_empty_leader: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.leader_count == '0)) |-> (result.leader_value == '0))
		else $error("leader value without a count");

	a_final_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.final_res) |=> (result.leader_count == '0 && !result.overflow))
		else $error("set not cleared after final item");
`endif

endmodule

FILE: tb/flt_checker.sv
// ----------------------------------------------------------------------------
// flt_checker
// Watches the item and result channels of the frequency leader tracker,
// keeps its own copy of the value table and leader, predicts the leader
// result of every accepted item and compares each strobed result with the
// oldest prediction. Hands the mismatch count and the number of results
// still owed to the top.
// ----------------------------------------------------------------------------
module flt_checker import flt_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  logic    busy,
	input  item_t   item,
	input  logic    done,
	input  result_t result,
	output int      mismatches,
	output int      leaders_owed
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [VALUE_W-1:0]       key_mem [TABLE_ENTRIES];
	count_t                   cnt_mem [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] live;
	int                       used_n;
	logic [VALUE_W-1:0]       lead_val;
	count_t                   lead_cnt;
	logic                     dropped;
	result_t                  leader_q [$];

	function automatic void clear_set();
		live     = '0;
		used_n   = 0;
		lead_val = '0;
		lead_cnt = '0;
		dropped  = 1'b0;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t ns flt_checker: %s got %0h expected %0h", $realtime, what,
			got, want);
		mismatches++;
	endtask

	// Count one value into the table and return the leader it leaves behind.
	function automatic result_t tally_item(input item_t it);
		result_t     r;
		int          slot;
		bit          found;
		bit          counted;
		logic [63:0] wide;
		slot    = 0;
		found   = 1'b0;
		counted = 1'b0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (!found && live[i] && key_mem[i] == it.value) begin
				slot  = i;
				found = 1'b1;
			end
		end
		if (found) begin
			if (cnt_mem[slot] != COUNT_MAX)
				cnt_mem[slot] = cnt_mem[slot] + 1'b1;
			counted = 1'b1;
		end else if (used_n < TABLE_ENTRIES) begin
			for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
				if (!live[i])
					slot = i;
			end
			live[slot]    = 1'b1;
			key_mem[slot] = it.value;
			cnt_mem[slot] = count_t'(1);
			used_n++;
			counted = 1'b1;
		end else begin
			dropped = 1'b1;
		end
		// strictly greater: ties keep the earlier leader
		if (counted && cnt_mem[slot] > lead_cnt) begin
			lead_val = it.value;
			lead_cnt = cnt_mem[slot];
		end
		wide = 64'(lead_cnt);
		r.leader_value = lead_val;
		r.leader_count = wide[FIELD_COUNT_W-1:0];
		r.overflow     = dropped;
		r.final_res    = it.last;
		if (it.last)
			clear_set();
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			clear_set();
			leader_q.delete();
			mismatches   = 0;
			leaders_owed = 0;
		end else begin
			if (done) begin
				if (leader_q.size() == 0) begin
					report_mismatch("result with none expected", 64'(result), '0);
				end else begin
					want = leader_q.pop_front();
					if (result.leader_value !== want.leader_value)
						report_mismatch("leader_value", 64'(result.leader_value),
							64'(want.leader_value));
					if (result.leader_count !== want.leader_count)
						report_mismatch("leader_count", 64'(result.leader_count),
							64'(want.leader_count));
					if (result.overflow !== want.overflow)
						report_mismatch("overflow", 64'(result.overflow), 64'(want.overflow));
					if (result.final_res !== want.final_res)
						report_mismatch("final_res", 64'(result.final_res),
							64'(want.final_res));
				end
			end
			if (start && !busy)
				leader_q.push_back(tally_item(item));
			leaders_owed = leader_q.size();
		end
	end

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the frequency leader tracker. Drives directed
// sets (extreme values, ties, leader changes), random sets with repeated
// values and sets that overflow the table, with random gaps between items.
// The checker does the prediction.
// ----------------------------------------------------------------------------
module tb_top import flt_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT      = 3_000_000;
	localparam int DRAIN      = 2 * TABLE_ENTRIES + 64;
	localparam int RAND_ITEMS = 550;

	logic    clk    = 1'b0;
	logic    arst_n = 1'b0;
	logic    start  = 1'b0;
	item_t   item_bus = '0;
	logic    busy;
	logic    done;
	result_t result_bus;
	int      mismatches;
	int      leaders_owed;
	int      cycles = 0;

	frequency_leader_tracker DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item_bus),
		.busy   (busy),
		.done   (done),
		.result (result_bus)
	);

	flt_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item_bus),
		.done         (done),
		.result       (result_bus),
		.mismatches   (mismatches),
		.leaders_owed (leaders_owed)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	// Mostly back to back, some short pauses, a few long ones.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [VALUE_W-1:0] pick_value();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return '0;
			3: return '1;
			4, 5: return VALUE_W'($urandom_range(0, 15) - 8);
			default: return $urandom;
		endcase
	endfunction

	// Called at a falling edge; returns at the falling edge after the item
	// is taken, with start still high.
	task automatic send_item(input logic [VALUE_W-1:0] v, input logic lst, input int gap);
		if (gap > 0 || busy) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
			while (busy) @(negedge clk);
		end
		start    <= 1'b1;
		item_bus <= '{value: v, last: lst};
		@(negedge clk);
	endtask

	task automatic send(input logic [VALUE_W-1:0] v, input logic lst);
		send_item(v, lst, pick_gap());
	endtask

	initial begin : stimulus
		int                 sent;
		int                 len;
		int                 npool;
		int                 extra;
		logic [VALUE_W-1:0] base;
		logic [VALUE_W-1:0] v;
		logic [VALUE_W-1:0] pool [8];

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// extremes, a leader change, a tie that keeps the earlier leader
		send(32'h7fff_ffff, 1'b0);
		send(32'h8000_0000, 1'b0);
		send(32'h8000_0000, 1'b0);
		send(32'h7fff_ffff, 1'b0);
		send(32'h0000_0000, 1'b0);
		send(32'hffff_ffff, 1'b0);
		send(32'h0000_0000, 1'b0);
		send(32'h0000_0000, 1'b0);
		send(32'hffff_ffff, 1'b1);
		// single-item sets
		send(32'h5555_5555, 1'b1);
		send(32'haaaa_aaaa, 1'b1);
		// first value ties the leader, which stays, then overtakes it
		send(32'h0000_0007, 1'b0);
		send(32'h0000_0009, 1'b0);
		send(32'h0000_0009, 1'b0);
		send(32'h0000_0007, 1'b0);
		send(32'h0000_0007, 1'b1);

		sent = 0;
		while (sent < RAND_ITEMS) begin
			if ($urandom_range(0, 11) == 0) begin
				// fill the table, drop new values, then hit and miss a full table
				base  = $urandom;
				extra = $urandom_range(1, 6);
				for (int i = 0; i < TABLE_ENTRIES + extra; i++)
					send(base + VALUE_W'(i), 1'b0);
				len = $urandom_range(2, 10);
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(0, 1))
						v = base + VALUE_W'($urandom_range(0, 3));
					else
						v = base + VALUE_W'(TABLE_ENTRIES + 16 + i);
					send(v, i == len - 1);
				end
				sent += TABLE_ENTRIES + extra + len;
			end else begin
				len   = $urandom_range(1, 24);
				npool = $urandom_range(1, 8);
				for (int p = 0; p < npool; p++)
					pool[p] = pick_value();
				for (int i = 0; i < len; i++)
					send(pool[$urandom_range(0, npool - 1)], i == len - 1);
				sent += len;
			end
		end

		start <= 1'b0;
		while (leaders_owed != 0) @(negedge clk);
		repeat (DRAIN) @(negedge clk);
		if (mismatches == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
